// ===== hdl/dual_ring_uart_bridge_buffer_core_assert.svh =====
// Assertion macros for the dual ring UART bridge buffer core.
// Expects aclk and aresetn in the scope where they are used.
`ifndef DUAL_RING_UART_BRIDGE_BUFFER_CORE_ASSERT_SVH
`define DUAL_RING_UART_BRIDGE_BUFFER_CORE_ASSERT_SVH

// Same-cycle implication.
`define DRUB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DRUB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/drub_pkg.sv =====
// Shared types, constants and pointer helpers for the dual ring bridge core.
// No dependencies.
`default_nettype none

package drub_pkg;

    localparam int RING_DEPTH = 256;
    localparam int CHUNK      = 64;

    localparam int PTR_W     = $clog2(RING_DEPTH);
    localparam int LEN_W     = $clog2(CHUNK + 1);
    localparam int CMP_W     = (PTR_W > LEN_W) ? PTR_W : LEN_W;
    localparam int FILL_W    = (PTR_W > 8) ? PTR_W : 8;
    localparam int CFG_IDX_W = 2;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [LEN_W-1:0] len_t;

    typedef enum logic [2:0] {
        MODE_RX_A    = 3'd0,
        MODE_RX_B    = 3'd1,
        MODE_DRAIN_A = 3'd2,
        MODE_DRAIN_B = 3'd3,
        MODE_TX_DONE = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        KIND_STORED   = 3'd0,
        KIND_DROPPED  = 3'd1,
        KIND_DATA     = 3'd2,
        KIND_EMPTY    = 3'd3,
        KIND_BUSY     = 3'd4,
        KIND_DISABLED = 3'd5,
        KIND_CLOSED   = 3'd6
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALF_DUPLEX_A  = 2'd0,
        CFG_HALF_DUPLEX_B  = 2'd1,
        CFG_FORWARD_A_TO_B = 2'd2,
        CFG_FORWARD_B_TO_A = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_DRAIN = 1'b1
    } state_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] rx_data;
        logic       tx_ok;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  tx_data;
        logic        dest_port;
        logic        last;
        logic [7:0]  fill_a;
        logic [7:0]  fill_b;
        logic [31:0] overflow_a_count;
        logic [31:0] overflow_b_count;
        logic [31:0] echo_count;
        logic [31:0] error_count;
        logic [31:0] sent_to_a_count;
        logic [31:0] sent_to_b_count;
    } out_word_t;

    function automatic ptr_t ptr_inc(ptr_t p);
        if (p == PTR_W'(RING_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    // Entries from t up to h, modulo the ring depth.
    function automatic ptr_t ptr_dist(ptr_t h, ptr_t t);
        logic [PTR_W:0] s;
        if (h >= t) begin
            s = {1'b0, h} - {1'b0, t};
        end else begin
            s = {1'b0, h} + (PTR_W+1)'(RING_DEPTH) - {1'b0, t};
        end
        return s[PTR_W-1:0];
    endfunction

    function automatic ptr_t ptr_add(ptr_t p, ptr_t n);
        logic [PTR_W:0] s;
        s = {1'b0, p} + {1'b0, n};
        if (s >= (PTR_W+1)'(RING_DEPTH)) begin
            s = s - (PTR_W+1)'(RING_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    function automatic len_t chunk_take(ptr_t fill);
        if (CMP_W'(fill) > CMP_W'(CHUNK)) begin
            return LEN_W'(CHUNK);
        end
        return LEN_W'(fill);
    endfunction

    function automatic logic [7:0] fill8(ptr_t d);
        logic [FILL_W-1:0] w;
        w = FILL_W'(d);
        return w[7:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/drub_ram.sv =====
// Simple dual-port ring storage: one write port, one registered read port.
// No dependencies.
`default_nettype none

module drub_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dual_ring_uart_bridge_buffer_core.sv =====
// Dual ring UART bridge buffer core; uses drub_pkg, drub_ram and the assert header.
// Byte-in, transmit-done and refused drains: one word out, pushed into the output queue.
// Drain of n bytes: one byte per cycle while the output queue has room, from the ring
// memory read port; the next word is taken once the last read has landed.
// Sync active-low reset clears pointers, pending state, counters and output queue;
// ring contents stay undefined and get no clearing pass.
`default_nettype none

module dual_ring_uart_bridge_buffer_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire drub_pkg::in_word_t             s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output drub_pkg::out_word_t                 m_data,
    input  wire logic                           cfg_wr_en,
    input  wire logic [drub_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic                           cfg_wr_data
);

    `include "dual_ring_uart_bridge_buffer_core_assert.svh"

    drub_pkg::state_t state_reg, state_next;

    drub_pkg::ptr_t head_a_reg, head_a_next, tail_a_reg, tail_a_next;
    drub_pkg::ptr_t head_b_reg, head_b_next, tail_b_reg, tail_b_next;
    drub_pkg::ptr_t rd_ptr_reg, rd_ptr_next, snap_reg, snap_next;
    drub_pkg::len_t rem_reg, rem_next, pend_len_reg, pend_len_next;

    logic pend_busy_reg, pend_busy_next;
    logic pend_port_reg, pend_port_next;
    logic echo_open_reg, echo_open_next;
    logic src_reg, src_next;
    logic rd_pend_reg, rd_last_reg;

    logic [31:0] ovf_a_reg, ovf_a_next, ovf_b_reg, ovf_b_next;
    logic [31:0] echo_reg, echo_next, err_reg, err_next;
    logic [31:0] sent_a_reg, sent_a_next, sent_b_reg, sent_b_next;

    logic hd_a_reg, hd_b_reg, fwd_ab_reg, fwd_ba_reg;

    // two-word output queue, q0 is the head
    drub_pkg::out_word_t q0_reg, q0_next, q1_reg, q1_next, push_word;
    logic [1:0] q_count_reg, q_count_next;

    logic        s_fire, pop, push, push_dest, push_last, rd_issue;
    logic [2:0]  push_kind;
    logic [7:0]  push_data, ram_a_rdata, ram_b_rdata;
    logic        ram_a_we, ram_b_we, ram_a_re, ram_b_re;
    logic [2:0]  occ;

    drub_pkg::ptr_t nx_head_a, nx_head_b;
    logic           full_a, full_b;
    logic           dr_from_a, dr_en, dr_dest_hd;
    drub_pkg::ptr_t dr_head, dr_tail, dr_fill, dr_tail_new, dr_dest_head;
    drub_pkg::len_t dr_take;
    drub_pkg::ptr_t tx_head, tx_echo;

    drub_ram #(.DEPTH(drub_pkg::RING_DEPTH), .WIDTH(8)) u_ring_a (
        .clk     (aclk),
        .wr_en   (ram_a_we),
        .wr_addr (head_a_reg),
        .wr_data (s_data.rx_data),
        .rd_en   (ram_a_re),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_a_rdata)
    );

    drub_ram #(.DEPTH(drub_pkg::RING_DEPTH), .WIDTH(8)) u_ring_b (
        .clk     (aclk),
        .wr_en   (ram_b_we),
        .wr_addr (head_b_reg),
        .wr_data (s_data.rx_data),
        .rd_en   (ram_b_re),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_b_rdata)
    );

    assign pop     = m_valid && m_ready;
    assign m_valid = (q_count_reg != 2'd0);
    assign m_data  = q0_reg;
    assign s_ready = (state_reg == drub_pkg::ST_IDLE) && !rd_pend_reg && (q_count_reg != 2'd2);
    assign s_fire  = s_valid && s_ready;

    // issue a read only when its word is sure to find a queue slot
    assign occ      = {1'b0, q_count_reg} + {2'b00, rd_pend_reg};
    assign rd_issue = (state_reg == drub_pkg::ST_DRAIN) &&
                      ((occ < 3'd2) || (pop && (occ == 3'd2)));
    assign ram_a_re = rd_issue && !src_reg;
    assign ram_b_re = rd_issue && src_reg;

    assign nx_head_a = drub_pkg::ptr_inc(head_a_reg);
    assign nx_head_b = drub_pkg::ptr_inc(head_b_reg);
    assign full_a    = (nx_head_a == tail_a_reg);
    assign full_b    = (nx_head_b == tail_b_reg);

    assign dr_from_a    = (s_data.mode == drub_pkg::MODE_DRAIN_A);
    assign dr_en        = dr_from_a ? fwd_ab_reg : fwd_ba_reg;
    assign dr_head      = dr_from_a ? head_a_reg : head_b_reg;
    assign dr_tail      = dr_from_a ? tail_a_reg : tail_b_reg;
    assign dr_fill      = drub_pkg::ptr_dist(dr_head, dr_tail);
    assign dr_take      = drub_pkg::chunk_take(dr_fill);
    assign dr_tail_new  = drub_pkg::ptr_add(dr_tail, drub_pkg::PTR_W'(dr_take));
    assign dr_dest_hd   = dr_from_a ? hd_b_reg : hd_a_reg;
    assign dr_dest_head = dr_from_a ? head_b_reg : head_a_reg;

    assign tx_head = pend_port_reg ? head_b_reg : head_a_reg;
    assign tx_echo = drub_pkg::ptr_dist(tx_head, snap_reg);

    always_comb begin
        state_next     = state_reg;
        head_a_next    = head_a_reg;
        tail_a_next    = tail_a_reg;
        head_b_next    = head_b_reg;
        tail_b_next    = tail_b_reg;
        rd_ptr_next    = rd_ptr_reg;
        snap_next      = snap_reg;
        rem_next       = rem_reg;
        pend_len_next  = pend_len_reg;
        pend_busy_next = pend_busy_reg;
        pend_port_next = pend_port_reg;
        echo_open_next = echo_open_reg;
        src_next       = src_reg;
        ovf_a_next     = ovf_a_reg;
        ovf_b_next     = ovf_b_reg;
        echo_next      = echo_reg;
        err_next       = err_reg;
        sent_a_next    = sent_a_reg;
        sent_b_next    = sent_b_reg;
        push           = 1'b0;
        push_kind      = drub_pkg::KIND_STORED;
        push_data      = 8'd0;
        push_dest      = 1'b0;
        push_last      = 1'b1;
        ram_a_we       = 1'b0;
        ram_b_we       = 1'b0;

        // a ring read landed: forward it as a data word
        if (rd_pend_reg) begin
            push      = 1'b1;
            push_kind = drub_pkg::KIND_DATA;
            push_data = src_reg ? ram_b_rdata : ram_a_rdata;
            push_dest = pend_port_reg;
            push_last = rd_last_reg;
        end

        unique case (state_reg)
            drub_pkg::ST_IDLE: begin
                if (s_fire) begin
                    unique case (s_data.mode)
                        drub_pkg::MODE_RX_A: begin
                            push = 1'b1;
                            if (full_a) begin
                                ovf_a_next = ovf_a_reg + 32'd1;
                                push_kind  = drub_pkg::KIND_DROPPED;
                            end else begin
                                ram_a_we    = 1'b1;
                                head_a_next = nx_head_a;
                            end
                        end
                        drub_pkg::MODE_RX_B: begin
                            push = 1'b1;
                            if (full_b) begin
                                ovf_b_next = ovf_b_reg + 32'd1;
                                push_kind  = drub_pkg::KIND_DROPPED;
                            end else begin
                                ram_b_we    = 1'b1;
                                head_b_next = nx_head_b;
                            end
                        end
                        drub_pkg::MODE_DRAIN_A, drub_pkg::MODE_DRAIN_B: begin
                            push      = 1'b1;
                            push_dest = dr_from_a;
                            priority if (!dr_en) begin
                                push_kind = drub_pkg::KIND_DISABLED;
                            end else if (pend_busy_reg) begin
                                push_kind = drub_pkg::KIND_BUSY;
                            end else if (dr_fill == '0) begin
                                push_kind = drub_pkg::KIND_EMPTY;
                            end else begin
                                // commit the whole chunk now, stream the bytes after
                                push = 1'b0;
                                if (dr_from_a) begin
                                    tail_a_next = dr_tail_new;
                                end else begin
                                    tail_b_next = dr_tail_new;
                                end
                                pend_busy_next = 1'b1;
                                pend_port_next = dr_from_a;
                                pend_len_next  = dr_take;
                                echo_open_next = dr_dest_hd;
                                snap_next      = dr_dest_hd ? dr_dest_head : '0;
                                rd_ptr_next    = dr_tail;
                                rem_next       = dr_take;
                                src_next       = !dr_from_a;
                                state_next     = drub_pkg::ST_DRAIN;
                            end
                        end
                        drub_pkg::MODE_TX_DONE: begin
                            push      = 1'b1;
                            push_kind = drub_pkg::KIND_CLOSED;
                            push_dest = pend_port_reg;
                            if (pend_busy_reg) begin
                                if (echo_open_reg) begin
                                    // roll back the echo heard during the transmit
                                    echo_next = echo_reg + 32'(tx_echo);
                                    if (pend_port_reg) begin
                                        head_b_next = snap_reg;
                                    end else begin
                                        head_a_next = snap_reg;
                                    end
                                end
                                if (s_data.tx_ok) begin
                                    if (pend_port_reg) begin
                                        sent_b_next = sent_b_reg + 32'(pend_len_reg);
                                    end else begin
                                        sent_a_next = sent_a_reg + 32'(pend_len_reg);
                                    end
                                end else begin
                                    err_next = err_reg + 32'd1;
                                end
                                pend_busy_next = 1'b0;
                                echo_open_next = 1'b0;
                                pend_len_next  = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            drub_pkg::ST_DRAIN: begin
                if (rd_issue) begin
                    rd_ptr_next = drub_pkg::ptr_inc(rd_ptr_reg);
                    rem_next    = rem_reg - drub_pkg::LEN_W'(1);
                    if (rem_reg == drub_pkg::LEN_W'(1)) begin
                        state_next = drub_pkg::ST_IDLE;
                    end
                end
            end
        endcase
    end

    // every word shows the state after its item completes
    always_comb begin
        push_word.kind             = push_kind;
        push_word.tx_data          = push_data;
        push_word.dest_port        = push_dest;
        push_word.last             = push_last;
        push_word.fill_a           = drub_pkg::fill8(drub_pkg::ptr_dist(head_a_next, tail_a_next));
        push_word.fill_b           = drub_pkg::fill8(drub_pkg::ptr_dist(head_b_next, tail_b_next));
        push_word.overflow_a_count = ovf_a_next;
        push_word.overflow_b_count = ovf_b_next;
        push_word.echo_count       = echo_next;
        push_word.error_count      = err_next;
        push_word.sent_to_a_count  = sent_a_next;
        push_word.sent_to_b_count  = sent_b_next;
    end

    always_comb begin
        q0_next      = q0_reg;
        q1_next      = q1_reg;
        q_count_next = q_count_reg;
        unique case ({push, pop})
            2'b10: begin
                if (q_count_reg == 2'd0) begin
                    q0_next = push_word;
                end else begin
                    q1_next = push_word;
                end
                q_count_next = q_count_reg + 2'd1;
            end
            2'b01: begin
                q0_next      = q1_reg;
                q_count_next = q_count_reg - 2'd1;
            end
            2'b11: begin
                if (q_count_reg == 2'd1) begin
                    q0_next = push_word;
                end else begin
                    q0_next = q1_reg;
                    q1_next = push_word;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= drub_pkg::ST_IDLE;
            head_a_reg    <= '0;
            tail_a_reg    <= '0;
            head_b_reg    <= '0;
            tail_b_reg    <= '0;
            rd_ptr_reg    <= '0;
            snap_reg      <= '0;
            rem_reg       <= '0;
            pend_len_reg  <= '0;
            pend_busy_reg <= 1'b0;
            pend_port_reg <= 1'b0;
            echo_open_reg <= 1'b0;
            src_reg       <= 1'b0;
            rd_pend_reg   <= 1'b0;
            rd_last_reg   <= 1'b0;
            ovf_a_reg     <= '0;
            ovf_b_reg     <= '0;
            echo_reg      <= '0;
            err_reg       <= '0;
            sent_a_reg    <= '0;
            sent_b_reg    <= '0;
            q_count_reg   <= 2'd0;
        end else begin
            state_reg     <= state_next;
            head_a_reg    <= head_a_next;
            tail_a_reg    <= tail_a_next;
            head_b_reg    <= head_b_next;
            tail_b_reg    <= tail_b_next;
            rd_ptr_reg    <= rd_ptr_next;
            snap_reg      <= snap_next;
            rem_reg       <= rem_next;
            pend_len_reg  <= pend_len_next;
            pend_busy_reg <= pend_busy_next;
            pend_port_reg <= pend_port_next;
            echo_open_reg <= echo_open_next;
            src_reg       <= src_next;
            rd_pend_reg   <= rd_issue;
            rd_last_reg   <= rd_issue && (rem_reg == drub_pkg::LEN_W'(1));
            ovf_a_reg     <= ovf_a_next;
            ovf_b_reg     <= ovf_b_next;
            echo_reg      <= echo_next;
            err_reg       <= err_next;
            sent_a_reg    <= sent_a_next;
            sent_b_reg    <= sent_b_next;
            q_count_reg   <= q_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hd_a_reg   <= 1'b1;
            hd_b_reg   <= 1'b0;
            fwd_ab_reg <= 1'b1;
            fwd_ba_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                drub_pkg::CFG_HALF_DUPLEX_A:  hd_a_reg   <= cfg_wr_data;
                drub_pkg::CFG_HALF_DUPLEX_B:  hd_b_reg   <= cfg_wr_data;
                drub_pkg::CFG_FORWARD_A_TO_B: fwd_ab_reg <= cfg_wr_data;
                drub_pkg::CFG_FORWARD_B_TO_A: fwd_ba_reg <= cfg_wr_data;
            endcase
        end
    end

    `DRUB_ASSERT_IMP(a_drain_pending, state_reg == drub_pkg::ST_DRAIN, pend_busy_reg, "drain without pending tx")
    `DRUB_ASSERT_IMP(a_drain_rem, state_reg == drub_pkg::ST_DRAIN, rem_reg != '0, "drain with no bytes left")
    `DRUB_ASSERT_IMP(a_queue_room, push && (q_count_reg == 2'd2), pop, "push into full output queue")
    `DRUB_ASSERT_NXT(a_tail_hold, state_reg == drub_pkg::ST_DRAIN, $stable(tail_a_reg) && $stable(tail_b_reg), "tail moved during drain")

endmodule

`default_nettype wire

// ===== tb/dual_ring_uart_bridge_buffer_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for dual_ring_uart_bridge_buffer_core: a scoreboard class
// predicts every result word from accepted input words and checks the result stream.
// Depends on drub_pkg and the core RTL only.

module dual_ring_uart_bridge_buffer_core_test;
    import drub_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_WORDS  = 48;
    localparam int PHASES        = 6;
    localparam int IDLE_PCT      = 16;
    localparam logic [2:0] FIRST_UNKNOWN_MODE = 3'(MODE_TX_DONE + 1);

    class bridge_scoreboard;
        logic [7:0]  rings [2][RING_DEPTH];
        int          head [2];
        int          tail [2];
        logic [31:0] overflow [2];
        logic [31:0] sent [2];
        logic [31:0] echo_total;
        logic [31:0] tx_errors;
        bit          half_duplex [2];
        bit          forward [2];   // index is the source ring
        bit          tx_open;
        bit          tx_port;
        int          tx_len;
        bit          echo_open;
        int          head_mark;
        out_word_t   expected_q [$];
        int          failures;

        function new();
            for (int p = 0; p < 2; p++) begin
                head[p] = 0;
                tail[p] = 0;
                overflow[p] = '0;
                sent[p] = '0;
                forward[p] = 1'b1;
            end
            half_duplex[0] = 1'b1;
            half_duplex[1] = 1'b0;
            echo_total = '0;
            tx_errors = '0;
            tx_open = 1'b0;
            tx_port = 1'b0;
            tx_len = 0;
            echo_open = 1'b0;
            head_mark = 0;
            failures = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, bit v);
            case (idx)
                CFG_HALF_DUPLEX_A:  half_duplex[0] = v;
                CFG_HALF_DUPLEX_B:  half_duplex[1] = v;
                CFG_FORWARD_A_TO_B: forward[0] = v;
                CFG_FORWARD_B_TO_A: forward[1] = v;
                default: ;
            endcase
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function logic [7:0] held_bytes(int p);
            return 8'((head[p] + RING_DEPTH - tail[p]) % RING_DEPTH);
        endfunction

        // Stamp fills and counters as they stand after the whole word.
        function void expect_word(kind_t k, logic [7:0] data, logic port, logic is_last);
            out_word_t r;
            r.kind = k;
            r.tx_data = data;
            r.dest_port = port;
            r.last = is_last;
            r.fill_a = held_bytes(0);
            r.fill_b = held_bytes(1);
            r.overflow_a_count = overflow[0];
            r.overflow_b_count = overflow[1];
            r.echo_count = echo_total;
            r.error_count = tx_errors;
            r.sent_to_a_count = sent[0];
            r.sent_to_b_count = sent[1];
            expected_q.push_back(r);
        endfunction

        function void note_word(in_word_t w);
            int src;
            int dst;
            int nx;
            logic [7:0] taken [$];
            case (w.mode)
                MODE_RX_A, MODE_RX_B: begin
                    src = (w.mode == MODE_RX_B) ? 1 : 0;
                    nx = (head[src] + 1) % RING_DEPTH;
                    if (nx == tail[src]) begin
                        overflow[src] = overflow[src] + 32'd1;
                        expect_word(KIND_DROPPED, 8'h00, 1'b0, 1'b1);
                    end else begin
                        rings[src][head[src]] = w.rx_data;
                        head[src] = nx;
                        expect_word(KIND_STORED, 8'h00, 1'b0, 1'b1);
                    end
                end
                MODE_DRAIN_A, MODE_DRAIN_B: begin
                    src = (w.mode == MODE_DRAIN_B) ? 1 : 0;
                    dst = 1 - src;
                    if (!forward[src]) begin
                        expect_word(KIND_DISABLED, 8'h00, 1'(dst), 1'b1);
                    end else if (tx_open) begin
                        expect_word(KIND_BUSY, 8'h00, 1'(dst), 1'b1);
                    end else begin
                        while (taken.size() < CHUNK && tail[src] != head[src]) begin
                            taken.push_back(rings[src][tail[src]]);
                            tail[src] = (tail[src] + 1) % RING_DEPTH;
                        end
                        if (taken.size() == 0) begin
                            expect_word(KIND_EMPTY, 8'h00, 1'(dst), 1'b1);
                        end else begin
                            tx_open = 1'b1;
                            tx_port = 1'(dst);
                            tx_len = taken.size();
                            // mark the destination's own ring so its echo can be undone
                            echo_open = half_duplex[dst];
                            head_mark = echo_open ? head[dst] : 0;
                            foreach (taken[i]) begin
                                expect_word(KIND_DATA, taken[i], 1'(dst), i == taken.size() - 1);
                            end
                        end
                    end
                end
                MODE_TX_DONE: begin
                    if (tx_open) begin
                        if (echo_open) begin
                            echo_total = echo_total +
                                32'((head[tx_port] + RING_DEPTH - head_mark) % RING_DEPTH);
                            head[tx_port] = head_mark;
                        end
                        if (w.tx_ok) begin
                            sent[tx_port] = sent[tx_port] + 32'(tx_len);
                        end else begin
                            tx_errors = tx_errors + 32'd1;
                        end
                        tx_open = 1'b0;
                        echo_open = 1'b0;
                        tx_len = 0;
                    end
                    expect_word(KIND_CLOSED, 8'h00, tx_port, 1'b1);
                end
                default: ;  // unused modes give no word
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                failures++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void check_word(out_word_t got);
            out_word_t want;
            if (expected_q.size() == 0) begin
                failures++;
                $display("%0t: unexpected word, expected none, got kind %0d tx_data %0h",
                         $time, got.kind, got.tx_data);
                return;
            end
            want = expected_q.pop_front();
            compare_field("kind", 32'(want.kind), 32'(got.kind));
            compare_field("tx_data", 32'(want.tx_data), 32'(got.tx_data));
            compare_field("dest_port", 32'(want.dest_port), 32'(got.dest_port));
            compare_field("last", 32'(want.last), 32'(got.last));
            compare_field("fill_a", 32'(want.fill_a), 32'(got.fill_a));
            compare_field("fill_b", 32'(want.fill_b), 32'(got.fill_b));
            compare_field("overflow_a_count", want.overflow_a_count, got.overflow_a_count);
            compare_field("overflow_b_count", want.overflow_b_count, got.overflow_b_count);
            compare_field("echo_count", want.echo_count, got.echo_count);
            compare_field("error_count", want.error_count, got.error_count);
            compare_field("sent_to_a_count", want.sent_to_a_count, got.sent_to_a_count);
            compare_field("sent_to_b_count", want.sent_to_b_count, got.sent_to_b_count);
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    in_word_t           s_data;
    logic               m_valid;
    logic               m_ready;
    out_word_t          m_data;
    logic               cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic               cfg_wr_data;

    bridge_scoreboard board;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    int counted_words = 0;

    dual_ring_uart_bridge_buffer_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    function automatic int idle_gap();
        int g;
        g = 0;
        if (!quiet) begin
            while ($urandom_range(99) < IDLE_PCT) g++;
        end
        return g;
    endfunction

    task automatic send_word(input in_word_t w);
        int gap;
        gap = idle_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_word(w);
        if (w.mode <= MODE_TX_DONE) counted_words++;
    endtask

    task automatic send_op(input logic [2:0] mode, input logic [7:0] data, input logic ok);
        in_word_t w;
        w.mode = mode;
        w.rx_data = data;
        w.tx_ok = ok;
        send_word(w);
    endtask

    // Drop valid and wait until the result stream has gone quiet.
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input bit v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= v;
        @(posedge aclk);
        board.set_reg(idx, v);
    endtask

    task automatic apply_setting(input bit hd_a, input bit hd_b, input bit fwd_ab,
                                 input bit fwd_ba);
        settle();
        write_reg(CFG_HALF_DUPLEX_A, hd_a);
        write_reg(CFG_HALF_DUPLEX_B, hd_b);
        write_reg(CFG_FORWARD_A_TO_B, fwd_ab);
        write_reg(CFG_FORWARD_B_TO_A, fwd_ba);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic directed_words();
        send_op(MODE_RX_A, 8'h00, 1'b0);
        send_op(MODE_RX_A, 8'hFF, 1'b1);
        send_op(MODE_RX_B, 8'hFF, 1'b0);
        send_op(MODE_RX_B, 8'h00, 1'b1);
        send_op(MODE_RX_B, 8'h5A, 1'b0);
        send_op(MODE_TX_DONE, 8'h00, 1'b1);   // nothing open yet
        send_op(MODE_DRAIN_A, 8'h00, 1'b0);   // B is full duplex at reset
        send_op(MODE_DRAIN_B, 8'h00, 1'b0);   // busy
        send_op(MODE_DRAIN_A, 8'h00, 1'b0);   // busy
        send_op(MODE_RX_B, 8'h11, 1'b0);
        send_op(MODE_TX_DONE, 8'hFF, 1'b1);
        send_op(MODE_DRAIN_A, 8'h00, 1'b0);   // ring A now empty
        send_op(MODE_DRAIN_B, 8'h00, 1'b0);   // toward half-duplex A
        send_op(MODE_RX_A, 8'hA5, 1'b0);      // echo
        send_op(MODE_RX_A, 8'h3C, 1'b1);      // echo
        send_op(MODE_TX_DONE, 8'h00, 1'b0);   // failed, roll back echo
        send_op(MODE_TX_DONE, 8'h00, 1'b0);   // already closed
        for (int i = 0; i < 3; i++) begin
            send_op(FIRST_UNKNOWN_MODE + 3'(i), 8'($urandom), 1'($urandom));
        end
        send_op(MODE_DRAIN_A, 8'h00, 1'b0);
        apply_setting(1'b0, 1'b1, 1'b0, 1'b0);
        send_op(MODE_DRAIN_A, 8'h00, 1'b0);   // disabled
        send_op(MODE_DRAIN_B, 8'h00, 1'b0);   // disabled
        send_op(MODE_RX_A, 8'h80, 1'b0);
        send_op(MODE_TX_DONE, 8'h00, 1'b1);
    endtask

    // Receiver stalls while ring A is overfilled, so the core backs up.
    task automatic fill_under_stall();
        apply_setting(1'b1, 1'b0, 1'b1, 1'b1);
        hold_req = 1'b1;
        for (int i = 0; i < RING_DEPTH; i++) begin
            send_op(MODE_RX_A, 8'($urandom), 1'($urandom));
        end
        settle();
    endtask

    task automatic random_phase(input int n_words);
        int start;
        int dir;
        in_word_t w;
        start = counted_words;
        while (counted_words - start < n_words) begin
            if ($urandom_range(99) < 70) begin
                // bytes in, a drain, its echo, then the transmit outcome
                repeat ($urandom_range(0, 10)) begin
                    send_op($urandom_range(0, 1) ? MODE_RX_B : MODE_RX_A, 8'($urandom),
                            1'($urandom));
                end
                dir = $urandom_range(0, 1);
                send_op(dir ? MODE_DRAIN_B : MODE_DRAIN_A, 8'($urandom), 1'($urandom));
                repeat ($urandom_range(0, 4)) begin
                    send_op(dir ? MODE_RX_A : MODE_RX_B, 8'($urandom), 1'($urandom));
                end
                send_op(MODE_TX_DONE, 8'($urandom), 1'($urandom_range(99) < 75));
            end else begin
                w.mode = 3'($urandom_range(0, 7));
                w.rx_data = 8'($urandom);
                w.tx_ok = 1'($urandom);
                send_word(w);
            end
        end
    endtask

    initial begin : receiver
        int hold_left;
        hold_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_word(m_data);
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        board = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_wr_en = 1'b0;
        cfg_addr = CFG_HALF_DUPLEX_A;
        cfg_wr_data = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        directed_words();
        fill_under_stall();
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: apply_setting(1'b1, 1'b1, 1'b1, 1'b1);
                1: apply_setting(1'b0, 1'b0, 1'b1, 1'b1);
                2: apply_setting(1'b0, 1'b0, 1'b0, 1'b0);
                3: apply_setting(1'b1, 1'b0, 1'b1, 1'b1);
                default: apply_setting(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
            endcase
            quiet = (p == 1);
            random_phase(RANDOM_WORDS / PHASES);
        end
        quiet = 1'b0;
        settle();

        if (board.failures == 0 && board.outstanding() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/drub_pkg.sv
hdl/drub_ram.sv
hdl/dual_ring_uart_bridge_buffer_core.sv
tb/dual_ring_uart_bridge_buffer_core_test.sv
